// ===== rtl/core/tpbe_pkg.sv =====
// Package for the tape pulse block encoder.
// Holds the item opcodes, the queued job record, the queue status and the ROM tables.
// No dependencies.
package tpbe_pkg;

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_DATA  = 2'd1,
      OP_END   = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CSR_SPEED_MODE    = 2'd0,
      CSR_RATE_48K      = 2'd1,
      CSR_SYMBOL_OFFSET = 2'd2,
      CSR_PILOT_COUNT   = 2'd3
   } csr_index_type;

   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = $clog2(QueueDepth);

   localparam logic [5:0] START_LAST_STEP = 6'd54;
   localparam logic [5:0] DATA_LAST_STEP  = 6'd7;
   localparam logic [5:0] END_LAST_STEP   = 6'd3;
   localparam logic [5:0] HDR_FIRST_STEP  = 6'd5;
   localparam logic [5:0] HDR_LAST_STEP   = 6'd52;

   typedef struct packed {
      op_type      kind;
      logic [15:0] pilots;
      logic        rate_48k;
      logic [23:0] word;
      logic [7:0]  data;
      logic [2:0]  velo;
      logic [4:0]  term;
   } job_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

   localparam logic [2:0] FIRST_HALF [32] = '{
      3'd1, 3'd2, 3'd2, 3'd3, 3'd2, 3'd2, 3'd3, 3'd3,
      3'd2, 3'd3, 3'd3, 3'd4, 3'd3, 3'd3, 3'd4, 3'd4,
      3'd1, 3'd2, 3'd3, 3'd4, 3'd2, 3'd3, 3'd4, 3'd5,
      3'd2, 3'd3, 3'd4, 3'd5, 3'd3, 3'd4, 3'd5, 3'd6};

   localparam logic [2:0] SECOND_HALF [32] = '{
      3'd1, 3'd1, 3'd2, 3'd2, 3'd1, 3'd2, 3'd2, 3'd3,
      3'd2, 3'd2, 3'd3, 3'd3, 3'd2, 3'd3, 3'd3, 3'd4,
      3'd1, 3'd2, 3'd3, 3'd4, 3'd1, 3'd2, 3'd3, 3'd4,
      3'd2, 3'd3, 3'd4, 3'd5, 3'd2, 3'd3, 3'd4, 3'd5};

   localparam logic [7:0] SPEED_REF [16] = '{
      8'hed, 8'hde, 8'hd2, 8'hc3, 8'h00, 8'h71, 8'h62, 8'h53,
      8'hf1, 8'he5, 8'hd6, 8'hc7, 8'h04, 8'h78, 8'h69, 8'h5d};

   localparam logic [4:0] TERM_WIDTH [16] = '{
      5'd21, 5'd22, 5'd23, 5'd24, 5'd23, 5'd24, 5'd25, 5'd26,
      5'd13, 5'd14, 5'd15, 5'd16, 5'd15, 5'd16, 5'd17, 5'd18};

endpackage

// ===== rtl/core/tape_pulse_block_encoder_core.sv =====
// Tape pulse block encoder, top level: front end, job queue and back end.
// The front takes items while the 4-entry queue has room. An idle block queues a taken item,
// then the back end registers its first result. Throughput: one result per cycle from the
// back-end sequencer while a job is queued and the result register is free or being read.
// Reset (synchronous) empties the queue and result register, zeroes the output level and
// returns the registers to speed 0, 44.1 kHz, offset 0, pilot count 1.
module tape_pulse_block_encoder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_data_byte,
   input  logic [7:0]  req_flag_byte,
   input  logic [7:0]  req_block_checksum,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_pulse_width,
   output logic [15:0] rsp_repeat_count,
   output logic        rsp_first_level,
   output logic        rsp_last_of_run
);

   tpbe_pkg::q_status_type q_stat;
   tpbe_pkg::job_type      push_job;
   tpbe_pkg::job_type      head_job;
   logic                   q_push;
   logic                   q_pop;
   logic [5:0]             step;

   tpbe_front u_front (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_opcode         (req_opcode),
      .req_data_byte      (req_data_byte),
      .req_flag_byte      (req_flag_byte),
      .req_block_checksum (req_block_checksum),
      .q_stat             (q_stat),
      .q_push             (q_push),
      .q_job              (push_job)
   );

   tpbe_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .head_job (head_job),
      .stat     (q_stat)
   );

   tpbe_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_job         (head_job),
      .q_stat           (q_stat),
      .q_pop            (q_pop),
      .step             (step),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pulse_width  (rsp_pulse_width),
      .rsp_repeat_count (rsp_repeat_count),
      .rsp_first_level  (rsp_first_level),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_stat.full))
      else $error("queue push while full");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step <= tpbe_pkg::START_LAST_STEP)
      else $error("sequencer step out of range");

   a_pop_restarts: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (step == 6'd0) && rsp_valid && rsp_last_of_run)
      else $error("job end not seen as last result");

   a_width_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pulse_width != 5'd0) && (rsp_repeat_count != 16'd0))
      else $error("empty pulse run");

endmodule

// ===== rtl/core/tpbe_front.sv =====
// Front end: configuration registers, item intake and job building.
// Depends on tpbe_pkg.
module tpbe_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [1:0]             csr_index,
   input  logic [15:0]            csr_data,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_opcode,
   input  logic [7:0]             req_data_byte,
   input  logic [7:0]             req_flag_byte,
   input  logic [7:0]             req_block_checksum,
   input  tpbe_pkg::q_status_type q_stat,
   output logic                   q_push,
   output tpbe_pkg::job_type      q_job
);

   logic [2:0]  speed_mode_ff, speed_mode_in;
   logic        rate_48k_ff, rate_48k_in;
   logic [2:0]  offset_ff, offset_in;
   logic [15:0] pilot_ff, pilot_in;

   logic [3:0]  sel;
   logic [7:0]  ref_base;
   logic [6:0]  off7;
   logic [6:0]  off_x3;
   logic [6:0]  ref_low;
   tpbe_pkg::op_type op;

   assign csr_ready = 1'b1;

   always_comb begin
      speed_mode_in = speed_mode_ff;
      rate_48k_in   = rate_48k_ff;
      offset_in     = offset_ff;
      pilot_in      = pilot_ff;
      if (csr_valid) begin
         unique case (tpbe_pkg::csr_index_type'(csr_index))
            tpbe_pkg::CSR_SPEED_MODE:    speed_mode_in = csr_data[2:0];
            tpbe_pkg::CSR_RATE_48K:      rate_48k_in   = csr_data[0];
            tpbe_pkg::CSR_SYMBOL_OFFSET: offset_in     = csr_data[2:0];
            tpbe_pkg::CSR_PILOT_COUNT:   pilot_in      = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_mode_ff <= 3'd0;
         rate_48k_ff   <= 1'b0;
         offset_ff     <= 3'd0;
         pilot_ff      <= 16'd1;
      end else begin
         speed_mode_ff <= speed_mode_in;
         rate_48k_ff   <= rate_48k_in;
         offset_ff     <= offset_in;
         pilot_ff      <= pilot_in;
      end
   end

   // speed reference: top bit kept, low seven wrap
   always_comb begin
      sel      = {rate_48k_ff, speed_mode_ff};
      ref_base = tpbe_pkg::SPEED_REF[sel];
      off7     = {{4{offset_ff[2]}}, offset_ff};
      off_x3   = off7 + {off7[5:0], 1'b0};
      ref_low  = ref_base[6:0] + off_x3;
   end

   assign op        = tpbe_pkg::op_type'(req_opcode);
   assign req_ready = !q_stat.full;
   assign q_push    = req_valid && req_ready && (op != tpbe_pkg::OP_NONE);

   always_comb begin
      q_job.kind     = op;
      q_job.pilots   = {pilot_ff[15:1], 1'b1};
      q_job.rate_48k = rate_48k_ff;
      q_job.word     = {req_block_checksum, req_flag_byte, ref_base[7], ref_low};
      q_job.data     = req_data_byte;
      q_job.velo     = speed_mode_ff;
      q_job.term     = tpbe_pkg::TERM_WIDTH[sel];
   end

endmodule

// ===== rtl/core/tpbe_queue.sv =====
// Short job queue between the front and back ends.
// Depends on tpbe_pkg.
module tpbe_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  tpbe_pkg::job_type      push_job,
   input  logic                   pop,
   output tpbe_pkg::job_type      head_job,
   output tpbe_pkg::q_status_type stat
);

   tpbe_pkg::job_type slot_ff [tpbe_pkg::QueueDepth];
   logic [tpbe_pkg::QueuePtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [tpbe_pkg::QueuePtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [tpbe_pkg::QueuePtrW:0]   count_ff, count_in;
   logic do_push, do_pop;

   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == (tpbe_pkg::QueuePtrW+1)'(tpbe_pkg::QueueDepth));
   assign head_job   = slot_ff[rd_ptr_ff];

   assign do_push = push && !stat.full;
   assign do_pop  = pop && !stat.empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== rtl/core/tpbe_back.sv =====
// Back end: steps queued jobs to the result register, one pulse run per cycle unless stalled.
// Depends on tpbe_pkg.
module tpbe_back (
   input  logic                   clock,
   input  logic                   reset,
   input  tpbe_pkg::job_type      head_job,
   input  tpbe_pkg::q_status_type q_stat,
   output logic                   q_pop,
   output logic [5:0]             step,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [4:0]             rsp_pulse_width,
   output logic [15:0]            rsp_repeat_count,
   output logic                   rsp_first_level,
   output logic                   rsp_last_of_run
);

   logic [5:0]  step_ff, step_in;
   logic        level_ff, level_in;
   logic        valid_ff, valid_in;
   logic [4:0]  width_ff;
   logic [15:0] count_ff;
   logic        first_ff;
   logic        last_ff;

   logic [4:0]  res_width;
   logic [15:0] res_count;
   logic        res_last;
   logic        emit;
   logic [5:0]  hdr_j;
   logic [4:0]  hdr_bit;
   logic [1:0]  sym;
   logic [4:0]  tab_idx;
   logic [4:0]  term_half;

   always_comb begin
      hdr_j     = step_ff - tpbe_pkg::HDR_FIRST_STEP;
      hdr_bit   = 5'd23 - hdr_j[5:1];
      case (step_ff[2:1])
         2'd0:    sym = head_job.data[7:6];
         2'd1:    sym = head_job.data[5:4];
         2'd2:    sym = head_job.data[3:2];
         default: sym = head_job.data[1:0];
      endcase
      tab_idx   = {head_job.velo, sym};
      term_half = {1'b0, head_job.term[4:1]};

      res_width = 5'd1;
      res_count = 16'd1;
      res_last  = 1'b0;
      unique case (head_job.kind)
         tpbe_pkg::OP_START: begin
            res_last = (step_ff == tpbe_pkg::START_LAST_STEP);
            if (step_ff == 6'd0) begin
               res_width = 5'd12;
               res_count = head_job.pilots;
            end else if (step_ff == 6'd1) begin
               res_width = 5'd28;
            end else if (step_ff == 6'd2) begin
               res_width = 5'd12;
               res_count = 16'd6;
            end else if (step_ff == 6'd3) begin
               res_width = 5'd2;
            end else if (step_ff == 6'd4) begin
               res_width = head_job.rate_48k ? 5'd4 : 5'd8;
            end else if (step_ff <= tpbe_pkg::HDR_LAST_STEP) begin
               res_width = head_job.word[hdr_bit] ? 5'd4 : 5'd8;
            end else if (step_ff == 6'd53) begin
               res_width = 5'd2;
            end else begin
               res_width = 5'd3;
            end
         end
         tpbe_pkg::OP_DATA: begin
            res_last  = (step_ff == tpbe_pkg::DATA_LAST_STEP);
            res_width = step_ff[0] ? {2'b00, tpbe_pkg::SECOND_HALF[tab_idx]}
                                   : {2'b00, tpbe_pkg::FIRST_HALF[tab_idx]};
         end
         tpbe_pkg::OP_END: begin
            res_last = (step_ff == tpbe_pkg::END_LAST_STEP);
            if (step_ff == 6'd0) begin
               res_width = term_half;
            end else if (step_ff == 6'd1) begin
               res_width = head_job.term - term_half;
            end else begin
               res_width = 5'd1;
            end
         end
         default: res_last = 1'b1;
      endcase
   end

   assign emit  = !q_stat.empty && (!valid_ff || rsp_ready);
   assign q_pop = emit && res_last;

   always_comb begin
      step_in  = step_ff;
      level_in = level_ff;
      valid_in = valid_ff && !rsp_ready;
      if (emit) begin
         step_in  = res_last ? 6'd0 : step_ff + 6'd1;
         level_in = level_ff ^ res_count[0];
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= 6'd0;
         level_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         level_ff <= level_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         width_ff <= res_width;
         count_ff <= res_count;
         first_ff <= level_ff;
         last_ff  <= res_last;
      end
   end

   assign step             = step_ff;
   assign rsp_valid        = valid_ff;
   assign rsp_pulse_width  = width_ff;
   assign rsp_repeat_count = count_ff;
   assign rsp_first_level  = first_ff;
   assign rsp_last_of_run  = last_ff;

endmodule

// ===== sim/tb_tape_pulse_block_encoder_core.sv =====
// Self-checking testbench for tape_pulse_block_encoder_core: directed table, then random blocks.
// Predicts every pulse run from its own copy of the encoding tables and registers.
// Depends on tpbe_pkg and the encoder core RTL only.
module tb_tape_pulse_block_encoder_core;

   localparam int RUN_LIMIT  = 600000;
   localparam int DRAIN_TAIL = 8;
   localparam int HOLD_LEN   = 400;

   localparam logic [0:31][2:0] HALF_A_ROM = {
      3'd1, 3'd2, 3'd2, 3'd3, 3'd2, 3'd2, 3'd3, 3'd3,
      3'd2, 3'd3, 3'd3, 3'd4, 3'd3, 3'd3, 3'd4, 3'd4,
      3'd1, 3'd2, 3'd3, 3'd4, 3'd2, 3'd3, 3'd4, 3'd5,
      3'd2, 3'd3, 3'd4, 3'd5, 3'd3, 3'd4, 3'd5, 3'd6};
   localparam logic [0:31][2:0] HALF_B_ROM = {
      3'd1, 3'd1, 3'd2, 3'd2, 3'd1, 3'd2, 3'd2, 3'd3,
      3'd2, 3'd2, 3'd3, 3'd3, 3'd2, 3'd3, 3'd3, 3'd4,
      3'd1, 3'd2, 3'd3, 3'd4, 3'd1, 3'd2, 3'd3, 3'd4,
      3'd2, 3'd3, 3'd4, 3'd5, 3'd2, 3'd3, 3'd4, 3'd5};
   localparam logic [0:15][7:0] REF_BYTE_ROM = {
      8'hed, 8'hde, 8'hd2, 8'hc3, 8'h00, 8'h71, 8'h62, 8'h53,
      8'hf1, 8'he5, 8'hd6, 8'hc7, 8'h04, 8'h78, 8'h69, 8'h5d};
   localparam logic [0:15][4:0] TAIL_ROM = {
      5'd21, 5'd22, 5'd23, 5'd24, 5'd23, 5'd24, 5'd25, 5'd26,
      5'd13, 5'd14, 5'd15, 5'd16, 5'd15, 5'd16, 5'd17, 5'd18};

   typedef struct packed {
      tpbe_pkg::op_type op;
      logic [7:0]       data;
      logic [7:0]       flag;
      logic [7:0]       csum;
   } tape_item_type;

   typedef struct packed {
      logic [4:0]  width;
      logic [15:0] count;
      logic        level;
      logic        last;
   } pulse_run_type;

   // typed rows: widths listed first-to-last from bit 39 down, count 1 each
   typedef struct packed {
      tape_item_type    it;
      logic             typed;
      logic [3:0]       n_typed;
      logic [7:0][4:0]  typed_w;
   } dir_row_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_opcode = '0;
   logic [7:0]  req_data_byte = '0;
   logic [7:0]  req_flag_byte = '0;
   logic [7:0]  req_block_checksum = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [4:0]  rsp_pulse_width;
   logic [15:0] rsp_repeat_count;
   logic        rsp_first_level;
   logic        rsp_last_of_run;

   pulse_run_type pulse_runs_due[$];
   logic        line_level = 1'b0;
   logic [2:0]  spd_mode = 3'd0;
   logic        at_48k = 1'b0;
   logic [2:0]  sym_off = 3'd0;
   logic [15:0] pilot_cfg = 16'd1;

   int          fail_count = 0;
   int          cycle_count = 0;
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   logic        hold_wanted = 1'b0;
   logic        hold_served = 1'b0;
   int          hold_left = 0;
   dir_row_type directed_rows [16];

   tape_pulse_block_encoder_core DUT (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index), .csr_data(csr_data),
      .req_valid(req_valid), .req_ready(req_ready), .req_opcode(req_opcode),
      .req_data_byte(req_data_byte), .req_flag_byte(req_flag_byte),
      .req_block_checksum(req_block_checksum),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_pulse_width(rsp_pulse_width),
      .rsp_repeat_count(rsp_repeat_count), .rsp_first_level(rsp_first_level),
      .rsp_last_of_run(rsp_last_of_run)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("tb_tape_pulse_block_encoder_core failed");
         $finish;
      end
   end

   function automatic void add_run(input logic [4:0] w, input logic [15:0] n);
      pulse_runs_due.push_back('{w, n, line_level, 1'b0});
      line_level = line_level ^ n[0];
   endfunction

   task automatic encode_item(input tape_item_type it);
      logic [3:0]    sel;
      logic [7:0]    base;
      logic [7:0]    spd_ref;
      logic [23:0]   hdr;
      logic [4:0]    w;
      logic [4:0]    term;
      logic [1:0]    sym;
      int            adj;
      int            due_before;
      pulse_run_type tail;
      sel = {at_48k, spd_mode};
      due_before = pulse_runs_due.size();
      case (it.op)
         tpbe_pkg::OP_START: begin
            add_run(5'd12, pilot_cfg | 16'd1);   // even counts go up by one
            add_run(5'd28, 16'd1);
            add_run(5'd12, 16'd6);
            add_run(5'd2, 16'd1);
            add_run(at_48k ? 5'd4 : 5'd8, 16'd1);
            base = REF_BYTE_ROM[sel];
            adj = int'(base) + 3 * int'($signed(sym_off));
            spd_ref = {base[7], 7'(adj)};
            hdr = {it.csum, it.flag, spd_ref};
            for (int j = 23; j >= 0; j--) begin
               w = hdr[j] ? 5'd4 : 5'd8;
               add_run(w, 16'd1);
               add_run(w, 16'd1);
            end
            add_run(5'd2, 16'd1);
            add_run(5'd3, 16'd1);
         end
         tpbe_pkg::OP_DATA: begin
            for (int s = 3; s >= 0; s--) begin
               sym = it.data[2*s +: 2];
               add_run(5'(HALF_A_ROM[{spd_mode, sym}]), 16'd1);
               add_run(5'(HALF_B_ROM[{spd_mode, sym}]), 16'd1);
            end
         end
         tpbe_pkg::OP_END: begin
            term = TAIL_ROM[sel];
            add_run(term >> 1, 16'd1);
            add_run(term - (term >> 1), 16'd1);
            add_run(5'd1, 16'd1);
            add_run(5'd1, 16'd1);
         end
         default: ;
      endcase
      if (pulse_runs_due.size() > due_before) begin
         tail = pulse_runs_due.pop_back();
         tail.last = 1'b1;
         pulse_runs_due.push_back(tail);
      end
   endtask

   task automatic offer_item(input tape_item_type it, input logic typed = 1'b0,
                             input logic [3:0] n_typed = 4'd0,
                             input logic [7:0][4:0] typed_w = '0);
      logic lvl;
      int   due_before;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= it.op;
      req_data_byte <= it.data;
      req_flag_byte <= it.flag;
      req_block_checksum <= it.csum;
      do @(posedge clock); while (!req_ready);
      lvl = line_level;
      due_before = pulse_runs_due.size();
      encode_item(it);
      if (typed) begin
         while (pulse_runs_due.size() > due_before) void'(pulse_runs_due.pop_back());
         for (int i = 0; i < n_typed; i++) begin
            pulse_runs_due.push_back('{typed_w[7-i], 16'd1, lvl, i == n_typed - 1});
            lvl = ~lvl;
         end
      end
   endtask

   task automatic write_csr(input tpbe_pkg::csr_index_type idx, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         tpbe_pkg::CSR_SPEED_MODE:    spd_mode = value[2:0];
         tpbe_pkg::CSR_RATE_48K:      at_48k = value[0];
         tpbe_pkg::CSR_SYMBOL_OFFSET: sym_off = value[2:0];
         tpbe_pkg::CSR_PILOT_COUNT:   pilot_cfg = value;
         default: ;
      endcase
   endtask

   task automatic drain_runs();
      req_valid <= 1'b0;
      while (pulse_runs_due.size() != 0) @(posedge clock);
      repeat (DRAIN_TAIL) @(posedge clock);
   endtask

   task automatic run_phase(input logic [2:0] spd, input logic rate, input logic [2:0] off,
                            input logic [15:0] pilots, input int send_pct, input int rx_pct,
                            input int n_items, input logic hold);
      logic [7:0]    block_bytes [8];
      logic [7:0]    csum;
      int            nbytes;
      int            sent;
      tape_item_type it;
      drain_runs();
      write_csr(tpbe_pkg::CSR_SPEED_MODE, {13'($urandom), spd});
      write_csr(tpbe_pkg::CSR_RATE_48K, {15'($urandom), rate});
      write_csr(tpbe_pkg::CSR_SYMBOL_OFFSET, {13'($urandom), off});
      write_csr(tpbe_pkg::CSR_PILOT_COUNT, pilots);
      csr_valid <= 1'b0;
      send_idle_pct = send_pct;
      stall_pct = rx_pct;
      hold_wanted = hold;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(9) < 8) begin
            nbytes = $urandom_range(1, 6);
            csum = 8'd0;
            for (int i = 0; i < nbytes; i++) begin
               block_bytes[i] = 8'($urandom);
               csum = csum ^ block_bytes[i];
            end
            if ($urandom_range(7) == 0) csum = 8'($urandom);
            offer_item('{tpbe_pkg::OP_START, 8'($urandom), 8'($urandom), csum});
            for (int i = 0; i < nbytes; i++)
               offer_item('{tpbe_pkg::OP_DATA, block_bytes[i], 8'($urandom), 8'($urandom)});
            sent += nbytes + 1;
            if ($urandom_range(7) != 0) begin
               offer_item('{tpbe_pkg::OP_END, 8'($urandom), 8'($urandom), 8'($urandom)});
               sent++;
            end
         end else begin
            it = '{tpbe_pkg::op_type'($urandom_range(3)), 8'($urandom), 8'($urandom),
                   8'($urandom)};
            offer_item(it);
            if (it.op != tpbe_pkg::OP_NONE) sent++;
         end
      end
   endtask

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin : rx_side
      pulse_run_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pulse_runs_due.size() == 0) begin
            $display("%0t: unexpected run, expected none, got width %0d count %0d", $time,
                     rsp_pulse_width, rsp_repeat_count);
            fail_count++;
         end else begin
            want = pulse_runs_due.pop_front();
            check_field("pulse_width", 16'(want.width), 16'(rsp_pulse_width));
            check_field("repeat_count", want.count, rsp_repeat_count);
            check_field("first_level", 16'(want.level), 16'(rsp_first_level));
            check_field("last_of_run", 16'(want.last), 16'(rsp_last_of_run));
         end
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_wanted && !hold_served) begin
         hold_served = 1'b1;
         hold_left = HOLD_LEN;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   initial begin
      directed_rows[0]  = '{'{tpbe_pkg::OP_END, 8'h00, 8'h00, 8'h00}, 1'b1, 4'd4,
                            {5'd10, 5'd11, 5'd1, 5'd1, 20'd0}};
      directed_rows[1]  = '{'{tpbe_pkg::OP_DATA, 8'h00, 8'h00, 8'h00}, 1'b1, 4'd8,
                            {5'd1, 5'd1, 5'd1, 5'd1, 5'd1, 5'd1, 5'd1, 5'd1}};
      directed_rows[2]  = '{'{tpbe_pkg::OP_NONE, 8'hff, 8'hff, 8'hff}, 1'b1, 4'd0, 40'd0};
      directed_rows[3]  = '{'{tpbe_pkg::OP_DATA, 8'hff, 8'h00, 8'h00}, 1'b1, 4'd8,
                            {5'd3, 5'd2, 5'd3, 5'd2, 5'd3, 5'd2, 5'd3, 5'd2}};
      directed_rows[4]  = '{'{tpbe_pkg::OP_START, 8'h00, 8'h00, 8'h00}, 1'b0, 4'd0, 40'd0};
      directed_rows[5]  = '{'{tpbe_pkg::OP_START, 8'hff, 8'hff, 8'hff}, 1'b0, 4'd0, 40'd0};
      directed_rows[6]  = '{'{tpbe_pkg::OP_DATA, 8'h1b, 8'h00, 8'h00}, 1'b0, 4'd0, 40'd0};
      directed_rows[7]  = '{'{tpbe_pkg::OP_DATA, 8'he4, 8'hff, 8'hff}, 1'b0, 4'd0, 40'd0};
      directed_rows[8]  = '{'{tpbe_pkg::OP_DATA, 8'haa, 8'h00, 8'h00}, 1'b0, 4'd0, 40'd0};
      directed_rows[9]  = '{'{tpbe_pkg::OP_DATA, 8'h55, 8'h00, 8'h00}, 1'b0, 4'd0, 40'd0};
      directed_rows[10] = '{'{tpbe_pkg::OP_END, 8'hff, 8'hff, 8'hff}, 1'b1, 4'd4,
                            {5'd10, 5'd11, 5'd1, 5'd1, 20'd0}};
      directed_rows[11] = '{'{tpbe_pkg::OP_NONE, 8'h00, 8'h00, 8'h00}, 1'b1, 4'd0, 40'd0};
      directed_rows[12] = '{'{tpbe_pkg::OP_START, 8'h3c, 8'ha5, 8'h5a}, 1'b0, 4'd0, 40'd0};
      directed_rows[13] = '{'{tpbe_pkg::OP_DATA, 8'h80, 8'h00, 8'h00}, 1'b0, 4'd0, 40'd0};
      directed_rows[14] = '{'{tpbe_pkg::OP_DATA, 8'h01, 8'h00, 8'h00}, 1'b0, 4'd0, 40'd0};
      directed_rows[15] = '{'{tpbe_pkg::OP_END, 8'h00, 8'h00, 8'h00}, 1'b0, 4'd0, 40'd0};

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[r])
         offer_item(directed_rows[r].it, directed_rows[r].typed, directed_rows[r].n_typed,
                    directed_rows[r].typed_w);

      run_phase(3'd0, 1'b0, 3'd0, 16'd1, 0, 0, 30, 1'b0);
      run_phase(3'd7, 1'b1, 3'd3, 16'hffff, 88, 0, 40, 1'b0);
      run_phase(3'd4, 1'b0, 3'b100, 16'h0000, 0, 88, 40, 1'b0);
      run_phase(3'd3, 1'b1, 3'b110, 16'h0002, 16, 16, 40, 1'b1);
      run_phase(3'd5, 1'b0, 3'd2, 16'hfffe, 0, 0, 40, 1'b0);
      run_phase(3'($urandom), 1'($urandom), 3'($urandom), 16'($urandom), 16, 16, 35, 1'b0);
      run_phase(3'd1, 1'b1, 3'b111, 16'($urandom), 0, 16, 30, 1'b0);

      drain_runs();
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("tb_tape_pulse_block_encoder_core passed");
      else
         $display("tb_tape_pulse_block_encoder_core failed");
      $finish;
   end

endmodule
